FILE: rtl/ptns_pkg.sv
// ----------------------------------------------------------------------------
// ptns_pkg
// shared types, operation codes and widths for the point table search
// ----------------------------------------------------------------------------
package ptns_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int ID_W  = 16;
    localparam int POS_W = 16;
    localparam int D2_W  = 34;

    localparam logic [2:0] OP_INSERT  = 3'd0;
    localparam logic [2:0] OP_MOVE    = 3'd1;
    localparam logic [2:0] OP_KILL    = 3'd2;
    localparam logic [2:0] OP_NEAREST = 3'd3;
    localparam logic [2:0] OP_FIRST   = 3'd4;
    localparam logic [2:0] OP_COMPACT = 3'd5;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic             alive;
        logic [ID_W-1:0]  ident;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
    } t_entry;

    // control broadcast to every cell
    typedef struct packed {
        logic             rotate;
        logic             load;
        logic             drop;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic             clear_alive;
        logic             move;
    } t_cell_ctrl;

endpackage

FILE: rtl/ptns_cell.sv
// ----------------------------------------------------------------------------
// ptns_cell
// one table slot; during a walk the row rotates one slot toward cell zero
// ----------------------------------------------------------------------------
module ptns_cell
    import ptns_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_entry     i_next,
    input  logic       i_is_head,
    output t_entry     o_entry
);
    t_entry r_e;
    t_entry n_e;

    always_comb begin
        n_e = r_e;
        if (i_ctrl.rotate) begin
            n_e = i_next;
        end
        if (i_is_head && i_ctrl.clear_alive) begin
            n_e.alive = 1'b0;
        end
        if (i_is_head && i_ctrl.move) begin
            n_e.x = i_ctrl.x;
            n_e.y = i_ctrl.y;
        end
        if (i_is_head && i_ctrl.drop) begin
            n_e.alive = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e.alive <= 1'b0;
        end else begin
            r_e.alive <= n_e.alive;
        end
        r_e.ident <= n_e.ident;
        r_e.x     <= n_e.x;
        r_e.y     <= n_e.y;
    end

    assign o_entry = r_e;
endmodule

FILE: rtl/point_table_nearest_search.sv
// ----------------------------------------------------------------------------
// point_table_nearest_search
// table of points kept in a rotating row of cells; one command at a time
// ----------------------------------------------------------------------------
// insert: the accepting edge moves to the result state, which strobes the result word.
// move, kill, searches, compact and unused codes walk the row once over every slot,
// then wait in the drain state until the distance pipeline is empty; the result
// state then forms the result and strobes it. busy is high until the result
// strobe, the result word cannot be stalled. synchronous active-low reset
// clears all alive marks, the fill count and the id counter at once.
module point_table_nearest_search
    import ptns_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [2:0]       i_operation,
    input  logic [ID_W-1:0]  i_target_id,
    input  logic [POS_W-1:0] i_pos_x,
    input  logic [POS_W-1:0] i_pos_y,
    input  logic [15:0]      i_radius,
    output logic             o_valid,
    output logic [1:0]       o_status,
    output logic [ID_W-1:0]  o_found_id
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_OUT = 2'd3;

    t_entry     w_e [TABLE_DEPTH];
    t_cell_ctrl w_ctrl;

    logic [1:0]       r_state;
    logic [2:0]       r_op;
    logic [ID_W-1:0]  r_tid;
    logic [POS_W-1:0] r_px, r_py;
    logic [31:0]      r_r2;
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    r_used;
    logic [CW-1:0]    r_wcnt;
    logic [ID_W-1:0]  r_next_id;
    logic             r_hit;
    logic [ID_W-1:0]  r_hit_id;
    logic [D2_W-1:0]  r_best;
    logic             r_ins;
    logic             r_ins_go;
    logic [1:0]       r_status;
    logic [ID_W-1:0]  r_fid;
    logic             r_valid;
    // distance pipeline
    logic             r_p1_v, r_p2_v;
    logic [16:0]      r_ax, r_ay;
    logic [ID_W-1:0]  r_p1_id, r_p2_id;
    logic [D2_W-1:0]  r_d2;

    t_entry w_head;
    logic   w_live;
    logic   w_match;
    logic   w_in_use;
    logic   w_cmp_on;
    logic   w_cmp_keep;
    logic   w_cmp_shift;
    logic [16:0] w_dx, w_dy;

    assign w_head   = w_e[0];
    assign w_in_use = r_cnt < r_used;
    assign w_live   = (r_state == S_WALK) && w_in_use && w_head.alive;
    assign w_match  = w_live && (r_op == OP_MOVE || r_op == OP_KILL)
                      && (w_head.ident == r_tid) && !r_hit;
    assign w_dx = {r_px[POS_W-1], r_px} - {w_head.x[POS_W-1], w_head.x};
    assign w_dy = {r_py[POS_W-1], r_py} - {w_head.y[POS_W-1], w_head.y};

    // compact: slots below r_wcnt are settled; a dead slot at r_wcnt is
    // squeezed out by shifting every cell above it down by one
    assign w_cmp_on    = (r_state == S_WALK) && (r_op == OP_COMPACT) && (r_wcnt < DEPTH_C);
    assign w_cmp_keep  = w_cmp_on && w_e[r_wcnt[AW-1:0]].alive;
    assign w_cmp_shift = w_cmp_on && !w_e[r_wcnt[AW-1:0]].alive;

    always_comb begin
        w_ctrl = '0;
        w_ctrl.x = r_px;
        w_ctrl.y = r_py;
        w_ctrl.rotate = (r_state == S_WALK) && (r_op != OP_COMPACT);
        w_ctrl.clear_alive = w_match && (r_op == OP_KILL);
        w_ctrl.move = w_match && (r_op == OP_MOVE);
        w_ctrl.load = r_ins_go;
    end

    t_entry w_ins;
    always_comb begin
        w_ins.alive = 1'b1;
        w_ins.ident = r_next_id;
        w_ins.x = r_px;
        w_ins.y = r_py;
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        t_entry w_nx;
        always_comb begin
            w_nx = w_e[(g + 1) % TABLE_DEPTH];
            if (g == TABLE_DEPTH - 1 && r_op == OP_COMPACT) begin
                w_nx = '0;
            end
        end
        t_entry w_src;
        t_cell_ctrl w_c;
        always_comb begin
            w_c = w_ctrl;
            w_src = w_nx;
            if (w_cmp_shift && CW'(g) >= r_wcnt) begin
                w_c.rotate = 1'b1;
            end
            if (w_ctrl.load && r_used[AW-1:0] == AW'(g)) begin
                w_c.rotate = 1'b1;
                w_src = w_ins;
            end
        end
        ptns_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (w_c),
            .i_next   (w_src),
            .i_is_head(g == TABLE_DEPTH - 1),
            .o_entry  (w_e[g])
        );
    end

    always_ff @(posedge i_clk) begin
        r_p1_v  <= 1'b0;
        r_ins_go <= 1'b0;
        r_valid <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used <= '0;
            r_next_id <= '0;
            r_p2_v <= 1'b0;
        end else begin
            r_p2_v <= r_p1_v;
            r_ax <= w_dx[16] ? -w_dx : w_dx;
            r_ay <= w_dy[16] ? -w_dy : w_dy;
            r_p1_id <= w_head.ident;
            r_p2_id <= r_p1_id;
            r_d2 <= D2_W'(r_ax * r_ax) + D2_W'(r_ay * r_ay);
            if (r_p2_v && r_d2 <= D2_W'(r_r2)) begin
                if (r_op == OP_NEAREST && (!r_hit || r_d2 < r_best)) begin
                    r_hit <= 1'b1;
                    r_best <= r_d2;
                    r_hit_id <= r_p2_id;
                end
                if (r_op == OP_FIRST && !r_hit) begin
                    r_hit <= 1'b1;
                    r_hit_id <= r_p2_id;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op <= i_operation;
                        r_tid <= i_target_id;
                        r_px <= i_pos_x;
                        r_py <= i_pos_y;
                        r_r2 <= 32'(i_radius) * 32'(i_radius);
                        r_cnt <= '0;
                        r_wcnt <= '0;
                        r_hit <= 1'b0;
                        r_best <= '0;
                        r_hit_id <= '0;
                        r_ins <= i_operation == OP_INSERT;
                        r_state <= (i_operation == OP_INSERT) ? S_OUT : S_WALK;
                        r_ins_go <= (i_operation == OP_INSERT) && (r_used != DEPTH_C);
                    end
                end
                S_WALK: begin
                    r_cnt <= r_cnt + 1'b1;
                    r_p1_v <= w_live;
                    if (w_match) begin
                        r_hit <= 1'b1;
                        r_hit_id <= r_tid;
                    end
                    if (w_cmp_keep) begin
                        r_wcnt <= r_wcnt + 1'b1;
                    end
                    if (r_cnt == DEPTH_C - 1'b1) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_p1_v && !r_p2_v) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_state <= S_IDLE;
                    r_valid <= 1'b1;
                    if (r_ins) begin
                        if (r_used == DEPTH_C) begin
                            r_status <= ST_FULL;
                            r_fid <= '0;
                        end else begin
                            r_status <= ST_DONE;
                            r_fid <= r_next_id;
                            r_next_id <= r_next_id + 1'b1;
                            r_used <= r_used + 1'b1;
                        end
                    end else if (r_op == OP_COMPACT) begin
                        r_status <= ST_DONE;
                        r_fid <= '0;
                        r_used <= r_wcnt;
                    end else if (r_op == OP_MOVE || r_op == OP_KILL || r_op == OP_NEAREST
                                 || r_op == OP_FIRST) begin
                        r_status <= r_hit ? ST_DONE : ST_NOTFOUND;
                        r_fid <= r_hit ? r_hit_id : '0;
                    end else begin
                        r_status <= ST_NOTFOUND;
                        r_fid <= '0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy = r_state != S_IDLE;
    assign o_valid = r_valid;
    assign o_status = r_status;
    assign o_found_id = r_fid;
endmodule
